@@ rtl/core/elpt_pkg.sv @@
package elpt_pkg;

    // Core geometry of the tracker.
    localparam int CPR_BITS  = 14;
    localparam int LUT_BITS  = 8;
    localparam int FRAC_BITS = 16;

    localparam int SEG_BITS  = CPR_BITS - LUT_BITS;
    localparam int SEG_IDX_W = (SEG_BITS > 0) ? SEG_BITS : 1;
    localparam int LUT_N     = 1 << LUT_BITS;
    localparam int POS_W     = CPR_BITS + FRAC_BITS;
    localparam int DELTA_W   = CPR_BITS + 1;

    // Fixed widths of the item fields and registers.
    localparam int RAW_W    = 14;
    localparam int TIDX_W   = 8;
    localparam int TVAL_W   = 15;
    localparam int TBL_W    = 16;
    localparam int CCNT_W   = 14;
    localparam int TD_W     = 15;
    localparam int ACC_W    = 32;
    localparam int TPOS_W   = 30;
    localparam int VEL_W    = 32;
    localparam int ZOFF_W   = 14;
    localparam int GAIN_W   = 16;
    localparam int SNAP_W   = 20;
    localparam int SEED_W   = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [SEED_W-1:0] SEED_RESET = 8'd20;

    // Conversion between the Q.16 gains and the FRAC_BITS position format.
    localparam int Q_SHL   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int Q_SHR   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int PROD_W  = GAIN_W + 1 + DELTA_W;
    localparam int PWIDE_W = PROD_W + Q_SHL;
    localparam int ADJ_W   = PROD_W + Q_SHL - Q_SHR;
    localparam int SNAPW_W = SNAP_W + Q_SHL;
    localparam int SNAPF_W = SNAP_W + Q_SHL - Q_SHR;
    localparam int PSUM_W  = (POS_W > VEL_W) ? POS_W : VEL_W;
    localparam int PADD_W  = (POS_W > ADJ_W) ? POS_W : ADJ_W;
    localparam int VSUM_W  = ((ADJ_W > VEL_W) ? ADJ_W : VEL_W) + 1;
    localparam int CMP_W   = (VEL_W + 1 > SNAPF_W) ? VEL_W + 1 : SNAPF_W;
    localparam int CALC_W  = ((CPR_BITS > TBL_W + 2) ? CPR_BITS : TBL_W + 2) + 2;

    localparam logic [CPR_BITS-1:0] SEG_MASK = CPR_BITS'((1 << SEG_BITS) - 1);

    localparam logic signed [DELTA_W:0] HALF_S = (DELTA_W + 1)'(1) <<< (CPR_BITS - 1);
    localparam logic signed [DELTA_W:0] CPR_S  = (DELTA_W + 1)'(1) <<< CPR_BITS;

    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W - 1){1'b0}}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_ERR,
        ST_MUL,
        ST_OUT
    } elpt_state_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REVERSE      = 3'd0,
        CFG_ZERO_OFFSET  = 3'd1,
        CFG_PROP_GAIN    = 3'd2,
        CFG_INTEG_GAIN   = 3'd3,
        CFG_SNAP_LIMIT   = 3'd4,
        CFG_INIT_SAMPLES = 3'd5
    } elpt_cfg_t;

    // Fold a difference of two counts into [-CPR/2, CPR/2].
    function automatic logic signed [DELTA_W-1:0] wrap_half(input logic signed [DELTA_W-1:0] d);
        logic signed [DELTA_W:0] w;
        w = (DELTA_W + 1)'(d);
        if (w > HALF_S)
            w = w - CPR_S;
        else if (w < -HALF_S)
            w = w + CPR_S;
        return DELTA_W'(w);
    endfunction

endpackage

@@ rtl/core/elpt_in_if.sv @@
// Input channel: angle samples and calibration table writes.
interface elpt_in_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [elpt_pkg::RAW_W-1:0]         raw_angle;
    logic [elpt_pkg::TIDX_W-1:0]        table_index;
    logic signed [elpt_pkg::TVAL_W-1:0] table_value;

    modport source (output valid, func, raw_angle, table_index, table_value, input ready);
    modport sink   (input valid, func, raw_angle, table_index, table_value, output ready);
endinterface

@@ rtl/core/elpt_out_if.sv @@
// Output channel: one tracker result per angle sample.
interface elpt_out_if;
    logic                              valid;
    logic                              ready;
    logic [elpt_pkg::CCNT_W-1:0]       corrected_count;
    logic signed [elpt_pkg::TD_W-1:0]  turn_delta;
    logic signed [elpt_pkg::ACC_W-1:0] accumulated_count;
    logic [elpt_pkg::TPOS_W-1:0]       tracked_position;
    logic signed [elpt_pkg::VEL_W-1:0] tracked_velocity;
    logic                              seeding;

    modport source (output valid, corrected_count, turn_delta, accumulated_count,
                    tracked_position, tracked_velocity, seeding, input ready);
    modport sink   (input valid, corrected_count, turn_delta, accumulated_count,
                    tracked_position, tracked_velocity, seeding, output ready);
endinterface

@@ rtl/core/elpt_ram.sv @@
// Simple dual-port RAM with one write port and a registered read port.
module elpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/encoder_linearize_pll_tracker_core.sv @@
// Encoder linearizer and PLL tracker. Each angle sample item is mirrored if
// requested, corrected by interpolating between two entries of a 256-entry
// calibration offset table, shifted by the zero offset and wrapped into one
// turn; it then seeds the tracker or updates the turn delta, the running count
// and a second-order PLL, and yields one result item. A table write item
// is written on acceptance and yields no result. Other items wait while a
// tracking sample steps through LO, HI, ERR, MUL and OUT and a seeding one
// through LO, HI and ERR: the two table neighbors are read in turn via the
// single read port of the table RAM, and the loop gains are applied in a
// registered multiply stage. The finished result waits in an output register,
// so a new item is taken while it is still pending; the block stalls only when
// the next result is ready before the previous one has been taken. The table
// reads as all zero after reset without any clearing pass.
module encoder_linearize_pll_tracker_core (
    input  logic                             clk,
    input  logic                             rst_n,
    elpt_in_if.sink                          samples,
    elpt_out_if.source                       results,
    input  logic                             cfg_we,
    input  logic [elpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [elpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CPR_BITS  = elpt_pkg::CPR_BITS;
    localparam int LUT_BITS  = elpt_pkg::LUT_BITS;
    localparam int FRAC_BITS = elpt_pkg::FRAC_BITS;
    localparam int SEG_BITS  = elpt_pkg::SEG_BITS;
    localparam int SEG_IDX_W = elpt_pkg::SEG_IDX_W;
    localparam int POS_W     = elpt_pkg::POS_W;
    localparam int DELTA_W   = elpt_pkg::DELTA_W;
    localparam int TBL_W     = elpt_pkg::TBL_W;
    localparam int VEL_W     = elpt_pkg::VEL_W;
    localparam int ACC_W     = elpt_pkg::ACC_W;
    localparam int PROD_W    = elpt_pkg::PROD_W;
    localparam int PWIDE_W   = elpt_pkg::PWIDE_W;
    localparam int ADJ_W     = elpt_pkg::ADJ_W;
    localparam int CALC_W    = elpt_pkg::CALC_W;
    localparam int PSUM_W    = elpt_pkg::PSUM_W;
    localparam int PADD_W    = elpt_pkg::PADD_W;
    localparam int VSUM_W    = elpt_pkg::VSUM_W;
    localparam int CMP_W     = elpt_pkg::CMP_W;
    localparam int SNAPW_W   = elpt_pkg::SNAPW_W;
    localparam int SNAPF_W   = elpt_pkg::SNAPF_W;
    localparam int Q_SHL     = elpt_pkg::Q_SHL;
    localparam int Q_SHR     = elpt_pkg::Q_SHR;

    // Configuration registers.
    logic                             reverse_reg;
    logic [elpt_pkg::ZOFF_W-1:0]      zero_offset_reg;
    logic [elpt_pkg::GAIN_W-1:0]      prop_gain_reg;
    logic [elpt_pkg::GAIN_W-1:0]      integ_gain_reg;
    logic [elpt_pkg::SNAP_W-1:0]      snap_limit_reg;
    logic [elpt_pkg::SEED_W-1:0]      seed_left_reg;

    // Tracker state.
    elpt_pkg::elpt_state_t            state_reg;
    elpt_pkg::elpt_state_t            state_next;
    logic [elpt_pkg::LUT_N-1:0]       tbl_valid_reg;
    logic [CPR_BITS-1:0]              prev_reg;
    logic [POS_W-1:0]                 pos_reg;
    logic signed [VEL_W-1:0]          vel_reg;
    logic [ACC_W-1:0]                 run_reg;

    // Per-sample working registers.
    logic [CPR_BITS-1:0]              raw_reg;
    logic signed [TBL_W-1:0]          lo_reg;
    logic [CPR_BITS-1:0]              count_reg;
    logic signed [DELTA_W-1:0]        delta_reg;
    logic signed [DELTA_W-1:0]        err_reg;
    logic [POS_W-1:0]                 pos1_reg;
    logic signed [PROD_W-1:0]         pprod_reg;
    logic signed [PROD_W-1:0]         iprod_reg;

    // Output register.
    logic                              out_valid_reg;
    logic [elpt_pkg::CCNT_W-1:0]       out_count_reg;
    logic signed [elpt_pkg::TD_W-1:0]  out_delta_reg;
    logic [ACC_W-1:0]                  out_acc_reg;
    logic [elpt_pkg::TPOS_W-1:0]       out_pos_reg;
    logic signed [VEL_W-1:0]           out_vel_reg;
    logic                              out_seed_reg;

    // Sequencer controls.
    logic accept;
    logic can_emit;
    logic ld_lo;
    logic ld_count;
    logic do_seed;
    logic do_track;
    logic ld_prod;
    logic do_out;

    // Table access.
    logic                  tbl_we;
    logic [LUT_BITS-1:0]   tbl_waddr;
    logic [TBL_W-1:0]      tbl_wdata;
    logic [LUT_BITS-1:0]   tbl_raddr;
    logic [TBL_W-1:0]      tbl_rdata;
    logic [CPR_BITS-1:0]   raw_in;
    logic [CPR_BITS-1:0]   raw_m;
    logic [LUT_BITS-1:0]   base_in;
    logic [LUT_BITS-1:0]   base_reg;
    logic [LUT_BITS-1:0]   base_nx;

    // Interpolation datapath.
    logic signed [TBL_W-1:0]            hi_val;
    logic [SEG_IDX_W-1:0]               seg_frac;
    logic signed [TBL_W:0]              diff;
    logic signed [TBL_W+SEG_IDX_W+1:0]  dprod;
    logic signed [TBL_W+1:0]            interp;
    logic signed [CALC_W-1:0]           ccalc;

    // Tracking datapath.
    logic signed [DELTA_W-1:0]  d_raw;
    logic signed [DELTA_W-1:0]  e_raw;
    logic [POS_W-1:0]           pos1;
    logic signed [PWIDE_W-1:0]  pwide;
    logic signed [PWIDE_W-1:0]  iwide;
    logic signed [ADJ_W-1:0]    padj;
    logic signed [ADJ_W-1:0]    iadj;
    logic [POS_W-1:0]           pos_new;
    logic signed [VSUM_W-1:0]   vsum;
    logic                       vovf;
    logic signed [VEL_W-1:0]    vsat;
    logic signed [VEL_W:0]      vext;
    logic [VEL_W:0]             vabs;
    logic [SNAPW_W-1:0]         snapw;
    logic [SNAPF_W-1:0]         snapf;
    logic signed [VEL_W-1:0]    vel_new;

    assign accept        = samples.valid && samples.ready;
    assign samples.ready = (state_reg == elpt_pkg::ST_IDLE);
    assign can_emit      = !out_valid_reg || results.ready;

    // Mirror and table addressing.
    assign raw_in    = CPR_BITS'(samples.raw_angle);
    assign raw_m     = reverse_reg ? ~raw_in : raw_in;
    assign base_in   = raw_m[CPR_BITS-1:SEG_BITS];
    assign base_reg  = raw_reg[CPR_BITS-1:SEG_BITS];
    assign base_nx   = base_reg + LUT_BITS'(1);
    assign tbl_raddr = (state_reg == elpt_pkg::ST_IDLE) ? base_in : base_nx;
    assign tbl_we    = accept && samples.func;
    assign tbl_waddr = LUT_BITS'(samples.table_index);
    assign tbl_wdata = TBL_W'(samples.table_value);

    elpt_ram #(
        .WIDTH (TBL_W),
        .DEPTH (elpt_pkg::LUT_N)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Interpolation and wrap into one turn; an entry never written reads as zero.
    always_comb
    begin
        hi_val   = tbl_valid_reg[base_nx] ? $signed(tbl_rdata) : '0;
        seg_frac = SEG_IDX_W'(raw_reg & elpt_pkg::SEG_MASK);
        diff     = (TBL_W + 1)'(hi_val) - (TBL_W + 1)'(lo_reg);
        dprod    = (TBL_W + SEG_IDX_W + 2)'(diff)
                   * (TBL_W + SEG_IDX_W + 2)'($signed({1'b0, seg_frac}));
        interp   = (TBL_W + 2)'(lo_reg) + (TBL_W + 2)'(dprod >>> SEG_BITS);
        ccalc    = CALC_W'($signed({1'b0, raw_reg})) - CALC_W'(interp)
                   - CALC_W'($signed({1'b0, zero_offset_reg}));
    end

    // Turn delta, predicted position and phase error.
    always_comb
    begin
        d_raw = $signed(DELTA_W'(count_reg) - DELTA_W'(prev_reg));
        pos1  = POS_W'(PSUM_W'(pos_reg) + PSUM_W'(vel_reg));
        e_raw = $signed(DELTA_W'(count_reg) - DELTA_W'(pos1[POS_W-1:FRAC_BITS]));
    end

    // Loop gain correction, velocity saturation and snap to zero.
    always_comb
    begin
        pwide   = PWIDE_W'(pprod_reg) <<< Q_SHL;
        iwide   = PWIDE_W'(iprod_reg) <<< Q_SHL;
        padj    = ADJ_W'(pwide >>> Q_SHR);
        iadj    = ADJ_W'(iwide >>> Q_SHR);
        pos_new = POS_W'(PADD_W'(pos1_reg) + PADD_W'(padj));
        vsum    = VSUM_W'(vel_reg) + VSUM_W'(iadj);
        vovf    = (vsum[VSUM_W-1:VEL_W-1] != '0) && (vsum[VSUM_W-1:VEL_W-1] != '1);
        if (vovf)
            vsat = vsum[VSUM_W-1] ? elpt_pkg::VEL_MIN : elpt_pkg::VEL_MAX;
        else
            vsat = vsum[VEL_W-1:0];
        vext    = (VEL_W + 1)'(vsat);
        vabs    = vext[VEL_W] ? (-vext) : vext;
        snapw   = SNAPW_W'(snap_limit_reg) << Q_SHL;
        snapf   = SNAPF_W'(snapw >> Q_SHR);
        vel_new = (CMP_W'(vabs) < CMP_W'(snapf)) ? '0 : vsat;
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= elpt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer next state and step controls.
    always_comb
    begin
        state_next = state_reg;
        ld_lo      = 1'b0;
        ld_count   = 1'b0;
        do_seed    = 1'b0;
        do_track   = 1'b0;
        ld_prod    = 1'b0;
        do_out     = 1'b0;
        case (state_reg)
            elpt_pkg::ST_IDLE:
            begin
                if (accept && !samples.func)
                    state_next = elpt_pkg::ST_LO;
            end
            elpt_pkg::ST_LO:
            begin
                ld_lo      = 1'b1;
                state_next = elpt_pkg::ST_HI;
            end
            elpt_pkg::ST_HI:
            begin
                ld_count   = 1'b1;
                state_next = elpt_pkg::ST_ERR;
            end
            elpt_pkg::ST_ERR:
            begin
                if (seed_left_reg != '0)
                begin
                    if (can_emit)
                    begin
                        do_seed    = 1'b1;
                        state_next = elpt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    do_track   = 1'b1;
                    state_next = elpt_pkg::ST_MUL;
                end
            end
            elpt_pkg::ST_MUL:
            begin
                ld_prod    = 1'b1;
                state_next = elpt_pkg::ST_OUT;
            end
            elpt_pkg::ST_OUT:
            begin
                if (can_emit)
                begin
                    do_out     = 1'b1;
                    state_next = elpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = elpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration writes, table valid bits and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg     <= 1'b0;
            zero_offset_reg <= '0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            snap_limit_reg  <= '0;
            seed_left_reg   <= elpt_pkg::SEED_RESET;
            tbl_valid_reg   <= '0;
            prev_reg        <= '0;
            pos_reg         <= '0;
            vel_reg         <= '0;
            run_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (elpt_pkg::elpt_cfg_t'(cfg_index))
                    elpt_pkg::CFG_REVERSE:      reverse_reg     <= cfg_data[0];
                    elpt_pkg::CFG_ZERO_OFFSET:  zero_offset_reg <= cfg_data[elpt_pkg::ZOFF_W-1:0];
                    elpt_pkg::CFG_PROP_GAIN:    prop_gain_reg   <= cfg_data[elpt_pkg::GAIN_W-1:0];
                    elpt_pkg::CFG_INTEG_GAIN:   integ_gain_reg  <= cfg_data[elpt_pkg::GAIN_W-1:0];
                    elpt_pkg::CFG_SNAP_LIMIT:   snap_limit_reg  <= cfg_data[elpt_pkg::SNAP_W-1:0];
                    elpt_pkg::CFG_INIT_SAMPLES: seed_left_reg   <= cfg_data[elpt_pkg::SEED_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            else if (do_seed)
            begin
                seed_left_reg <= seed_left_reg - elpt_pkg::SEED_W'(1);
            end

            if (tbl_we)
                tbl_valid_reg[tbl_waddr] <= 1'b1;

            if (do_seed)
            begin
                prev_reg <= count_reg;
                pos_reg  <= {count_reg, {FRAC_BITS{1'b0}}};
                vel_reg  <= '0;
            end
            if (do_track)
            begin
                prev_reg <= count_reg;
                run_reg  <= run_reg + ACC_W'(elpt_pkg::wrap_half(d_raw));
            end
            if (do_out)
            begin
                pos_reg <= pos_new;
                vel_reg <= vel_new;
            end
        end
    end

    // Per-sample working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            raw_reg <= raw_m;
        if (ld_lo)
            lo_reg <= tbl_valid_reg[base_reg] ? $signed(tbl_rdata) : '0;
        if (ld_count)
            count_reg <= ccalc[CPR_BITS-1:0];
        if (do_track)
        begin
            delta_reg <= elpt_pkg::wrap_half(d_raw);
            pos1_reg  <= pos1;
            err_reg   <= elpt_pkg::wrap_half(e_raw);
        end
        if (ld_prod)
        begin
            pprod_reg <= PROD_W'($signed({1'b0, prop_gain_reg})) * PROD_W'(err_reg);
            iprod_reg <= PROD_W'($signed({1'b0, integ_gain_reg})) * PROD_W'(err_reg);
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (do_seed || do_out)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (do_seed)
        begin
            out_count_reg <= elpt_pkg::CCNT_W'(count_reg);
            out_delta_reg <= '0;
            out_acc_reg   <= run_reg;
            out_pos_reg   <= elpt_pkg::TPOS_W'({count_reg, {FRAC_BITS{1'b0}}});
            out_vel_reg   <= '0;
            out_seed_reg  <= 1'b1;
        end
        else if (do_out)
        begin
            out_count_reg <= elpt_pkg::CCNT_W'(count_reg);
            out_delta_reg <= elpt_pkg::TD_W'(delta_reg);
            out_acc_reg   <= run_reg;
            out_pos_reg   <= elpt_pkg::TPOS_W'(pos_new);
            out_vel_reg   <= vel_new;
            out_seed_reg  <= 1'b0;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.corrected_count   = out_count_reg;
    assign results.turn_delta        = out_delta_reg;
    assign results.accumulated_count = $signed(out_acc_reg);
    assign results.tracked_position  = out_pos_reg;
    assign results.tracked_velocity  = out_vel_reg;
    assign results.seeding           = out_seed_reg;

`ifndef SYNTHESIS
    // A new result appears only from the seeding step or the final tracking step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == elpt_pkg::ST_ERR ||
                                  $past(state_reg) == elpt_pkg::ST_OUT))
        else $error("result appeared outside a commit step");

    // A seeding result never reports motion.
    a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_seed_reg) |-> (out_delta_reg == '0 && out_vel_reg == '0))
        else $error("seeding result carries a delta or a velocity");

    // A table write finishes in the cycle it is accepted.
    a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.func) |=> (state_reg == elpt_pkg::ST_IDLE))
        else $error("table write left the sequencer busy");

    // A result is never overwritten before it has been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (do_seed || do_out) |-> (!out_valid_reg || results.ready))
        else $error("pending result overwritten");
`endif

endmodule

@@ bench/encoder_linearize_pll_tracker_core_tb.sv @@
module encoder_linearize_pll_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits and the pause that lets a table write finish before a register write.
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 150;

    // Geometry of one turn in the predictor's wide arithmetic.
    localparam longint TURN = longint'(1) << elpt_pkg::CPR_BITS;
    localparam longint HALF_TURN = TURN / 2;
    localparam longint LUT_MASK = longint'(elpt_pkg::LUT_N - 1);
    localparam longint POS_MASK = (longint'(1) << elpt_pkg::POS_W) - 1;
    localparam longint WORD_MASK = 64'h0000_0000_FFFF_FFFF;
    localparam longint VEL_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint VEL_LO = -64'sh0000_0000_8000_0000;

    // Register indexes that the block has no register behind.
    localparam logic [elpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [elpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [elpt_pkg::CCNT_W-1:0]       corrected_count;
        logic signed [elpt_pkg::TD_W-1:0]  turn_delta;
        logic signed [elpt_pkg::ACC_W-1:0] accumulated_count;
        logic [elpt_pkg::TPOS_W-1:0]       tracked_position;
        logic signed [elpt_pkg::VEL_W-1:0] tracked_velocity;
        logic                              seeding;
    } tracker_result_t;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_TABLE,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [elpt_pkg::RAW_W-1:0]         raw;
        logic [elpt_pkg::TIDX_W-1:0]        tidx;
        logic signed [elpt_pkg::TVAL_W-1:0] tval;
        logic [elpt_pkg::CFG_IDX_W-1:0]     cidx;
        logic [elpt_pkg::CFG_DATA_W-1:0]    cdata;
        logic                               typed;
        tracker_result_t                    want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [elpt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [elpt_pkg::CFG_DATA_W-1:0] cfg_data;

    elpt_in_if  sample_ch ();
    elpt_out_if result_ch ();

    encoder_linearize_pll_tracker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tracker state as the predictor sees it.
    logic signed [elpt_pkg::TBL_W-1:0] cal_offsets [elpt_pkg::LUT_N];
    longint prev_count = 0;
    longint loop_pos = 0;
    longint loop_vel = 0;
    longint turn_sum = 0;
    int     seeds_left = int'(elpt_pkg::SEED_RESET);

    // Register copies.
    longint mirror_on = 0;
    longint zero_count = 0;
    longint kp_q16 = 0;
    longint ki_q16 = 0;
    longint snap_q16 = 0;

    tracker_result_t pending_results [$];
    stim_row_t directed_rows [$];
    int  mismatches = 0;
    int  cycle_count = 0;
    int  sink_hold = 0;
    bit  steady = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Fold a count difference into [-CPR/2, CPR/2].
    function automatic longint fold_half(input longint d);
        longint w;
        w = d;
        while (w > HALF_TURN)
            w -= TURN;
        while (w < -HALF_TURN)
            w += TURN;
        return w;
    endfunction

    // Bring a Q.16 product to the position fraction, flooring on a right shift.
    function automatic longint q16_scale(input longint x);
        if (elpt_pkg::FRAC_BITS >= 16)
            return x <<< (elpt_pkg::FRAC_BITS >= 16 ? elpt_pkg::FRAC_BITS - 16 : 0);
        return x >>> (elpt_pkg::FRAC_BITS < 16 ? 16 - elpt_pkg::FRAC_BITS : 0);
    endfunction

    // Linearize one angle sample and advance the seed or the tracking loop.
    function automatic tracker_result_t track_sample(
        input logic [elpt_pkg::RAW_W-1:0] angle_in);
        longint raw, base, frac, lo, hi, interp, count, delta, err, vel;
        tracker_result_t r;
        raw = longint'(angle_in);
        if (mirror_on != 0)
            raw = TURN - 1 - raw;
        base = (raw >> elpt_pkg::SEG_BITS) & LUT_MASK;
        frac = raw - (base << elpt_pkg::SEG_BITS);
        lo = longint'(cal_offsets[base]);
        hi = longint'(cal_offsets[(base + 1) & LUT_MASK]);
        interp = lo + (((hi - lo) * frac) >>> elpt_pkg::SEG_BITS);
        count = (raw - interp - zero_count) % TURN;
        if (count < 0)
            count += TURN;

        if (seeds_left != 0)
        begin
            prev_count = count;
            loop_pos = (count << elpt_pkg::FRAC_BITS) & POS_MASK;
            loop_vel = 0;
            seeds_left = (seeds_left - 1) & 255;
            delta = 0;
            r.seeding = 1'b1;
        end
        else
        begin
            delta = fold_half(count - prev_count);
            prev_count = count;
            turn_sum = (turn_sum + delta) & WORD_MASK;
            loop_pos = (loop_pos + loop_vel) & POS_MASK;
            err = fold_half(count - (loop_pos >> elpt_pkg::FRAC_BITS));
            loop_pos = (loop_pos + q16_scale(kp_q16 * err)) & POS_MASK;
            vel = loop_vel + q16_scale(ki_q16 * err);
            if (vel > VEL_HI)
                vel = VEL_HI;
            else if (vel < VEL_LO)
                vel = VEL_LO;
            if ((vel < 0 ? -vel : vel) < q16_scale(snap_q16))
                vel = 0;
            loop_vel = vel;
            r.seeding = 1'b0;
        end

        r.corrected_count = count[elpt_pkg::CCNT_W-1:0];
        r.turn_delta = delta[elpt_pkg::TD_W-1:0];
        r.accumulated_count = turn_sum[elpt_pkg::ACC_W-1:0];
        r.tracked_position = loop_pos[elpt_pkg::TPOS_W-1:0];
        r.tracked_velocity = loop_vel[elpt_pkg::VEL_W-1:0];
        return r;
    endfunction

    // Register write as the predictor sees it: each value masked to its width.
    function automatic void load_reg(input logic [elpt_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [elpt_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            elpt_pkg::CFG_REVERSE:
                mirror_on = longint'(data[0]);
            elpt_pkg::CFG_ZERO_OFFSET:
                zero_count = longint'(data[elpt_pkg::ZOFF_W-1:0]);
            elpt_pkg::CFG_PROP_GAIN:
                kp_q16 = longint'(data[elpt_pkg::GAIN_W-1:0]);
            elpt_pkg::CFG_INTEG_GAIN:
                ki_q16 = longint'(data[elpt_pkg::GAIN_W-1:0]);
            elpt_pkg::CFG_SNAP_LIMIT:
                snap_q16 = longint'(data[elpt_pkg::SNAP_W-1:0]);
            elpt_pkg::CFG_INIT_SAMPLES:
                seeds_left = int'(data[elpt_pkg::SEED_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic stim_row_t row_sample(input logic [elpt_pkg::RAW_W-1:0] raw);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.raw = raw;
        return row;
    endfunction

    function automatic stim_row_t row_seed(input logic [elpt_pkg::RAW_W-1:0] raw,
                                           input tracker_result_t want);
        stim_row_t row;
        row = row_sample(raw);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic stim_row_t row_table(input logic [elpt_pkg::TIDX_W-1:0] idx,
                                            input logic signed [elpt_pkg::TVAL_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_TABLE;
        row.tidx = idx;
        row.tval = val;
        return row;
    endfunction

    function automatic stim_row_t row_reg(input logic [elpt_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [elpt_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.cidx = idx;
        row.cdata = data;
        return row;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Present one item after a random gap (none while steady); predict it once accepted.
    // Entered and left at a falling edge; valid stays high on the way out.
    task automatic push_item(input stim_row_t row);
        tracker_result_t want;
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 4));
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.func = (row.kind == ROW_TABLE);
        sample_ch.raw_angle = (row.kind == ROW_SAMPLE) ? row.raw
                                                       : elpt_pkg::RAW_W'($urandom);
        sample_ch.table_index = (row.kind == ROW_TABLE) ? row.tidx
                                                        : elpt_pkg::TIDX_W'($urandom);
        sample_ch.table_value = (row.kind == ROW_TABLE) ? row.tval
                                                        : elpt_pkg::TVAL_W'($urandom);
        sample_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        if (row.kind == ROW_TABLE)
            cal_offsets[row.tidx] = elpt_pkg::TBL_W'(row.tval);
        else
        begin
            want = track_sample(row.raw);
            if (row.typed)
                want = row.want;
            pending_results.push_back(want);
        end
        @(negedge clk);
    endtask

    // Wait until every result is in, then let a trailing table write finish.
    task automatic drain_results();
        sample_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [elpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [elpt_pkg::CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        load_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Result side: hold ready low for a random number of cycles before each item.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready = 1'b0;
        else if (sink_hold > 0)
        begin
            result_ch.ready = 1'b0;
            sink_hold--;
        end
        else
            result_ch.ready = 1'b1;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        tracker_result_t got, want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.corrected_count = result_ch.corrected_count;
            got.turn_delta = result_ch.turn_delta;
            got.accumulated_count = result_ch.accumulated_count;
            got.tracked_position = result_ch.tracked_position;
            got.tracked_velocity = result_ch.tracked_velocity;
            got.seeding = result_ch.seeding;
            if (pending_results.size() == 0)
                flag_mismatch("result item with no expectation waiting");
            else
            begin
                want = pending_results.pop_front();
                if (got.corrected_count !== want.corrected_count)
                    flag_mismatch($sformatf("corrected_count %0d, expected %0d",
                                            got.corrected_count, want.corrected_count));
                if (got.turn_delta !== want.turn_delta)
                    flag_mismatch($sformatf("turn_delta %0d, expected %0d",
                                            got.turn_delta, want.turn_delta));
                if (got.accumulated_count !== want.accumulated_count)
                    flag_mismatch($sformatf("accumulated_count %0d, expected %0d",
                                            got.accumulated_count, want.accumulated_count));
                if (got.tracked_position !== want.tracked_position)
                    flag_mismatch($sformatf("tracked_position %0h, expected %0h",
                                            got.tracked_position, want.tracked_position));
                if (got.tracked_velocity !== want.tracked_velocity)
                    flag_mismatch($sformatf("tracked_velocity %0d, expected %0d",
                                            got.tracked_velocity, want.tracked_velocity));
                if (got.seeding !== want.seeding)
                    flag_mismatch($sformatf("seeding %0b, expected %0b",
                                            got.seeding, want.seeding));
            end
            sink_hold = steady ? 0 : int'($urandom_range(0, 4));
        end
    end

    // Watchdog over the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("encoder_linearize_pll_tracker_core_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int angle, speed, pick;
        logic [elpt_pkg::GAIN_W-1:0] gain;
        logic [elpt_pkg::SNAP_W-1:0] snap;
        stim_row_t row;

        foreach (cal_offsets[i])
            cal_offsets[i] = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.func = 1'b0;
        sample_ch.raw_angle = '0;
        sample_ch.table_index = '0;
        sample_ch.table_value = '0;
        result_ch.ready = 1'b0;

        // Directed rows. With the reset registers the first twenty samples seed the
        // tracker, so the first results can be read off directly.
        directed_rows.push_back(row_seed(14'd0,
            tracker_result_t'{14'd0, 15'sd0, 32'sd0, 30'h0000_0000, 32'sd0, 1'b1}));
        directed_rows.push_back(row_seed(14'd16383,
            tracker_result_t'{14'd16383, 15'sd0, 32'sd0, 30'h3FFF_0000, 32'sd0, 1'b1}));
        directed_rows.push_back(row_seed(14'd8192,
            tracker_result_t'{14'd8192, 15'sd0, 32'sd0, 30'h2000_0000, 32'sd0, 1'b1}));
        directed_rows.push_back(row_table(8'd0, -15'sd16384));
        directed_rows.push_back(row_table(8'd255, 15'sd16383));
        directed_rows.push_back(row_table(8'd1, 15'sd200));
        directed_rows.push_back(row_table(8'd128, -15'sd5));
        // The last table entry interpolates toward entry zero.
        directed_rows.push_back(row_sample(14'd16383));
        directed_rows.push_back(row_sample(14'd0));
        directed_rows.push_back(row_sample(14'd8200));
        // Reload the seed count, mirror the angle, use the widest gains and
        // out-of-range register bits.
        directed_rows.push_back(row_reg(elpt_pkg::CFG_INIT_SAMPLES, 20'd2));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_REVERSE, 20'd1));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_ZERO_OFFSET, 20'hFFFFF));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_PROP_GAIN, 20'hFFFFF));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_INTEG_GAIN, 20'h0FFFF));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_SNAP_LIMIT, 20'd0));
        directed_rows.push_back(row_reg(CFG_SPARE_HI, 20'hFFFFF));
        directed_rows.push_back(row_sample(14'd0));
        directed_rows.push_back(row_sample(14'd70));
        directed_rows.push_back(row_sample(14'd100));
        directed_rows.push_back(row_sample(14'd8292));
        directed_rows.push_back(row_sample(14'd16383));
        directed_rows.push_back(row_sample(14'd4000));
        // Largest snap limit: a velocity of smaller magnitude is forced to zero.
        directed_rows.push_back(row_reg(elpt_pkg::CFG_SNAP_LIMIT, 20'hFFFFF));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_REVERSE, 20'hFFFFE));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_ZERO_OFFSET, 20'd0));
        directed_rows.push_back(row_sample(14'd300));
        directed_rows.push_back(row_sample(14'd600));
        // No seeding at all, then zero gains.
        directed_rows.push_back(row_reg(elpt_pkg::CFG_INIT_SAMPLES, 20'd0));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_PROP_GAIN, 20'd0));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_INTEG_GAIN, 20'd0));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_SNAP_LIMIT, 20'd0));
        directed_rows.push_back(row_sample(14'd1000));
        directed_rows.push_back(row_table(8'd2, 15'sd16383));
        directed_rows.push_back(row_sample(14'd140));
        directed_rows.push_back(row_reg(elpt_pkg::CFG_INIT_SAMPLES, 20'd255));
        directed_rows.push_back(row_sample(14'd5000));

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(directed_rows[i].cidx, directed_rows[i].cdata);
            end
            else
                push_item(directed_rows[i]);
        end

        // Random phases: new registers, then a moving angle with jitter, some
        // jumps and some table writes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            write_reg(elpt_pkg::CFG_REVERSE, elpt_pkg::CFG_DATA_W'($urandom));
            write_reg(elpt_pkg::CFG_ZERO_OFFSET, elpt_pkg::CFG_DATA_W'($urandom));
            pick = $urandom_range(0, 5);
            gain = (pick == 0) ? '0 : (pick == 1) ? '1
                                    : elpt_pkg::GAIN_W'($urandom_range(500, 30000));
            write_reg(elpt_pkg::CFG_PROP_GAIN, elpt_pkg::CFG_DATA_W'(gain));
            pick = $urandom_range(0, 5);
            gain = (pick == 0) ? '0 : (pick == 1) ? '1
                                    : elpt_pkg::GAIN_W'($urandom_range(10, 3000));
            write_reg(elpt_pkg::CFG_INTEG_GAIN, elpt_pkg::CFG_DATA_W'(gain));
            pick = $urandom_range(0, 5);
            snap = (pick == 0) ? '0 : (pick == 1) ? '1
                                    : elpt_pkg::SNAP_W'($urandom_range(0, 200000));
            write_reg(elpt_pkg::CFG_SNAP_LIMIT, elpt_pkg::CFG_DATA_W'(snap));
            write_reg(elpt_pkg::CFG_INIT_SAMPLES,
                      (ph == 5) ? 20'd30 : elpt_pkg::CFG_DATA_W'($urandom_range(0, 6)));
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          elpt_pkg::CFG_DATA_W'($urandom));

            angle = $urandom_range(0, 16383);
            speed = $urandom_range(0, 600) - 300;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    if ($urandom_range(0, 1) == 0)
                        row = row_table(elpt_pkg::TIDX_W'($urandom),
                                        elpt_pkg::TVAL_W'($urandom_range(0, 128) - 64));
                    else
                        row = row_table(elpt_pkg::TIDX_W'($urandom),
                                        elpt_pkg::TVAL_W'($urandom));
                end
                else if (pick < 14)
                    row = row_sample(elpt_pkg::RAW_W'($urandom));
                else
                begin
                    angle = angle + speed;
                    row = row_sample(elpt_pkg::RAW_W'(angle + $urandom_range(0, 6) - 3));
                end
                push_item(row);
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("encoder_linearize_pll_tracker_core_tb OK");
        else
            $display("encoder_linearize_pll_tracker_core_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/elpt_pkg.sv
rtl/core/elpt_in_if.sv
rtl/core/elpt_out_if.sv
rtl/core/elpt_ram.sv
rtl/core/encoder_linearize_pll_tracker_core.sv
bench/encoder_linearize_pll_tracker_core_tb.sv
